FILE: hdl/nfdq_pkg.sv
// Shared types, constants and the NF4 level table of the NF4 double-quant dequantizer.
package nfdq_pkg;

  // Default build parameters.
  localparam int unsigned NFDQ_BLOCK_SIZE       = 64;
  localparam int unsigned NFDQ_BLOCKS_PER_SUPER = 256;
  localparam int unsigned NFDQ_INDEX_BITS       = 24;

  // Fixed field widths.
  localparam int unsigned IDX_W     = 24;
  localparam int unsigned VAL_W     = 8;
  localparam int unsigned CMD_W     = 2;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 24;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_SUPER  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_BLOCK  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_WEIGHT = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_START = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_END   = 2'd1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;      // input transfer this cycle
    logic calc_scale;  // register block scale times super scale
    logic calc_vals;   // register both dequantized values
    logic load_lo;     // load low-nibble result into the output register
    logic load_hi;     // load high-nibble result into the output register
    logic last;        // last flag for the result being loaded
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_full;  // output register holds a result not yet taken
    logic keep_lo;   // low-nibble element lies below the end index
    logic keep_hi;   // high-nibble element lies below the end index
  } dp_status_t;

  // NF4 levels in Q2.6.
  function automatic logic signed [VAL_W-1:0] nf4_level(input logic [3:0] code);
    logic signed [VAL_W-1:0] lvl;
    unique case (code)
      4'd0:  lvl = -8'sd64;
      4'd1:  lvl = -8'sd45;
      4'd2:  lvl = -8'sd34;
      4'd3:  lvl = -8'sd26;
      4'd4:  lvl = -8'sd19;
      4'd5:  lvl = -8'sd12;
      4'd6:  lvl = -8'sd6;
      4'd7:  lvl = 8'sd0;
      4'd8:  lvl = 8'sd5;
      4'd9:  lvl = 8'sd10;
      4'd10: lvl = 8'sd15;
      4'd11: lvl = 8'sd21;
      4'd12: lvl = 8'sd28;
      4'd13: lvl = 8'sd36;
      4'd14: lvl = 8'sd46;
      4'd15: lvl = 8'sd64;
    endcase
    return lvl;
  endfunction

endpackage

FILE: hdl/nfdq_ctrl.sv
// Controller state machine that sequences one input transfer through the datapath.
module nfdq_ctrl (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  input  logic [nfdq_pkg::CMD_W-1:0]          command_i,
  output logic                                in_ready_o,
  input  logic                                out_ready_i,
  input  nfdq_pkg::dp_status_t                status_i,
  output nfdq_pkg::dp_cmd_t                   cmd_o
);
  import nfdq_pkg::*;

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_SCALE   = 3'd1;
  localparam logic [2:0] ST_VALUE   = 3'd2;
  localparam logic [2:0] ST_EMIT_LO = 3'd3;
  localparam logic [2:0] ST_EMIT_HI = 3'd4;

  logic [2:0] state_q, state_d;
  logic       can_load;

  // The output register can take a result when empty or when being drained.
  assign can_load = !status_i.out_full || out_ready_i;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        if (in_valid_i && (command_i == CMD_WEIGHT)) begin
          state_d = ST_SCALE;
        end
      end
      ST_SCALE: begin
        cmd_o.calc_scale = 1'b1;
        state_d          = ST_VALUE;
      end
      ST_VALUE: begin
        cmd_o.calc_vals = 1'b1;
        if (status_i.keep_lo) begin
          state_d = ST_EMIT_LO;
        end else if (status_i.keep_hi) begin
          state_d = ST_EMIT_HI;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_EMIT_LO: begin
        if (can_load) begin
          cmd_o.load_lo = 1'b1;
          cmd_o.last    = !status_i.keep_hi;
          state_d       = status_i.keep_hi ? ST_EMIT_HI : ST_IDLE;
        end
      end
      ST_EMIT_HI: begin
        if (can_load) begin
          cmd_o.load_hi = 1'b1;
          cmd_o.last    = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: hdl/nfdq_datapath.sv
// Datapath: configuration, scale store, counters, two multiply stages and the output register.
module nfdq_datapath #(
  parameter int unsigned BLOCK_SIZE       = nfdq_pkg::NFDQ_BLOCK_SIZE,
  parameter int unsigned BLOCKS_PER_SUPER = nfdq_pkg::NFDQ_BLOCKS_PER_SUPER,
  parameter int unsigned INDEX_BITS       = nfdq_pkg::NFDQ_INDEX_BITS
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [nfdq_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [nfdq_pkg::CFG_DAT_W-1:0]        cfg_data_i,
  input  logic [nfdq_pkg::CMD_W-1:0]            command_i,
  input  logic signed [nfdq_pkg::VAL_W-1:0]     scale_value_i,
  input  logic [7:0]                            packed_byte_i,
  input  nfdq_pkg::dp_cmd_t                     cmd_i,
  output nfdq_pkg::dp_status_t                  status_o,
  input  logic                                  out_ready_i,
  output logic                                  out_valid_o,
  output logic [nfdq_pkg::IDX_W-1:0]            elem_index_o,
  output logic signed [nfdq_pkg::VAL_W-1:0]     value_o,
  output logic                                  last_o
);
  import nfdq_pkg::*;

  localparam int unsigned BPB    = ((BLOCK_SIZE / 2) < 1) ? 1 : (BLOCK_SIZE / 2);
  localparam int unsigned BYTE_W = (BPB > 1) ? $clog2(BPB) : 1;
  localparam int unsigned BLK_W  = (BLOCKS_PER_SUPER > 1) ? $clog2(BLOCKS_PER_SUPER) : 1;
  localparam int unsigned FILL_W = $clog2(BLOCKS_PER_SUPER + 1);
  localparam int unsigned CMP_W  = (INDEX_BITS > IDX_W) ? INDEX_BITS : IDX_W;

  // Configuration registers.
  logic [IDX_W-1:0] start_q, end_q;

  // Group state.
  logic signed [VAL_W-1:0] super_q;
  logic [FILL_W-1:0]       fill_q;
  logic [BLK_W-1:0]        blk_q;
  logic [BYTE_W-1:0]       byte_q;
  logic [INDEX_BITS-1:0]   offset_q;

  logic [VAL_W-1:0] scale_mem [BLOCKS_PER_SUPER];

  // Per-byte working registers.
  logic signed [VAL_W-1:0] rd_q, scale_q, val_lo_q, val_hi_q;
  logic [7:0]              codes_q;
  logic [IDX_W-1:0]        idx_lo_q, idx_hi_q;
  logic                    keep_lo_q, keep_hi_q;

  // Output register.
  logic                    out_valid_q, last_q;
  logic [IDX_W-1:0]        elem_index_q;
  logic signed [VAL_W-1:0] value_q;

  logic                    acc_block, acc_weight, acc_super;
  logic [INDEX_BITS-1:0]   idx_lo, idx_hi;
  logic [CMP_W-1:0]        start_ext, end_ext, idx_lo_ext, idx_hi_ext;
  logic                    byte_wrap, blk_wrap;
  logic signed [15:0]      prod_scale, prod_lo, prod_hi;

  assign acc_super  = cmd_i.accept && (command_i == CMD_SUPER);
  assign acc_block  = cmd_i.accept && (command_i == CMD_BLOCK);
  assign acc_weight = cmd_i.accept && (command_i == CMD_WEIGHT);

  // Element indices of the two codes, wrapped to the index width.
  assign start_ext  = CMP_W'(start_q);
  assign end_ext    = CMP_W'(end_q);
  assign idx_lo     = INDEX_BITS'(start_ext) + offset_q;
  assign idx_hi     = idx_lo + INDEX_BITS'(1);
  assign idx_lo_ext = CMP_W'(idx_lo);
  assign idx_hi_ext = CMP_W'(idx_hi);

  assign byte_wrap = (byte_q == BYTE_W'(BPB - 1));
  assign blk_wrap  = (blk_q == BLK_W'(BLOCKS_PER_SUPER - 1));

  // Q2.6 products: floor division by 64 is an arithmetic shift by six.
  assign prod_scale = rd_q * super_q;
  assign prod_lo    = nf4_level(codes_q[3:0]) * scale_q;
  assign prod_hi    = nf4_level(codes_q[7:4]) * scale_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= '0;
      end_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_START: start_q <= cfg_data_i;
        CFG_END:   end_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      super_q  <= '0;
      fill_q   <= '0;
      blk_q    <= '0;
      byte_q   <= '0;
      offset_q <= '0;
    end else begin
      if (acc_super) begin
        super_q <= scale_value_i;
        fill_q  <= '0;
        blk_q   <= '0;
        byte_q  <= '0;
      end
      if (acc_block && (fill_q < FILL_W'(BLOCKS_PER_SUPER))) begin
        fill_q <= fill_q + FILL_W'(1);
      end
      if (acc_weight) begin
        offset_q <= offset_q + INDEX_BITS'(2);
        if (byte_wrap) begin
          byte_q <= '0;
          blk_q  <= blk_wrap ? '0 : blk_q + BLK_W'(1);
        end else begin
          byte_q <= byte_q + BYTE_W'(1);
        end
      end
    end
  end

  // Block scale store with a registered read.
  always_ff @(posedge clk_i) begin
    if (acc_block && (fill_q < FILL_W'(BLOCKS_PER_SUPER))) begin
      scale_mem[fill_q[BLK_W-1:0]] <= scale_value_i;
    end
    if (acc_weight) begin
      rd_q <= scale_mem[blk_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_weight) begin
      codes_q   <= packed_byte_i;
      idx_lo_q  <= idx_lo_ext[IDX_W-1:0];
      idx_hi_q  <= idx_hi_ext[IDX_W-1:0];
      keep_lo_q <= (idx_lo_ext < end_ext);
      keep_hi_q <= (idx_hi_ext < end_ext);
    end
    if (cmd_i.calc_scale) begin
      scale_q <= prod_scale[13:6];
    end
    if (cmd_i.calc_vals) begin
      val_lo_q <= prod_lo[13:6];
      val_hi_q <= prod_hi[13:6];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_lo || cmd_i.load_hi) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_lo) begin
      elem_index_q <= idx_lo_q;
      value_q      <= val_lo_q;
      last_q       <= cmd_i.last;
    end else if (cmd_i.load_hi) begin
      elem_index_q <= idx_hi_q;
      value_q      <= val_hi_q;
      last_q       <= cmd_i.last;
    end
  end

  assign status_o.out_full = out_valid_q;
  assign status_o.keep_lo  = keep_lo_q;
  assign status_o.keep_hi  = keep_hi_q;

  assign out_valid_o  = out_valid_q;
  assign elem_index_o = elem_index_q;
  assign value_o      = value_q;
  assign last_o       = last_q;

endmodule

FILE: hdl/nf4_double_quant_dequantizer_core.sv
// Top level of the NF4 double-quant dequantizer: controller and datapath joined.
//
// This block turns a stream of commands into dequantized NF4 weights in Q2.6. A super-scale
// command (code 0) stores the group scale and restarts the scale-fill, block and byte counters;
// block-scale commands (code 1) fill the block scales of the group in order, and writes beyond
// the group's capacity are ignored. A weight-byte command (code 2) yields up to two results, low
// nibble first, each the NF4 level times the block scale times the super scale, every product
// floored and wrapped to 8 bits. Element indices start at start_index and advance by two per byte;
// results at or beyond end_index are dropped, and last marks the final result of a byte. Scale
// commands leave the block ready again in the next cycle. A weight byte runs through a
// registered read of the block-scale memory, the scale multiply and the level multiply, then
// moves each kept result into the output register, one per cycle while that register is empty
// or being drained. The output register lets the last result of a byte wait while the next
// input transfer is taken. The block-scale memory is not cleared; block scales must be written
// before bytes that use them.
module nf4_double_quant_dequantizer_core #(
  parameter int unsigned BLOCK_SIZE       = nfdq_pkg::NFDQ_BLOCK_SIZE,
  parameter int unsigned BLOCKS_PER_SUPER = nfdq_pkg::NFDQ_BLOCKS_PER_SUPER,
  parameter int unsigned INDEX_BITS       = nfdq_pkg::NFDQ_INDEX_BITS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration write port.
  input  logic                              cfg_we_i,
  input  logic [nfdq_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [nfdq_pkg::CFG_DAT_W-1:0]    cfg_data_i,
  // Input channel.
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [nfdq_pkg::CMD_W-1:0]        command_i,
  input  logic signed [nfdq_pkg::VAL_W-1:0] scale_value_i,
  input  logic [7:0]                        packed_byte_i,
  // Output channel.
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [nfdq_pkg::IDX_W-1:0]        elem_index_o,
  output logic signed [nfdq_pkg::VAL_W-1:0] value_o,
  output logic                              last_o
);
  import nfdq_pkg::*;

  // Sequencing commands and the status they depend on.
  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  nfdq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .command_i   (command_i),
    .in_ready_o  (in_ready_o),
    .out_ready_i (out_ready_i),
    .status_i    (dp_status),
    .cmd_o       (dp_cmd)
  );

  nfdq_datapath #(
    .BLOCK_SIZE       (BLOCK_SIZE),
    .BLOCKS_PER_SUPER (BLOCKS_PER_SUPER),
    .INDEX_BITS       (INDEX_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .command_i     (command_i),
    .scale_value_i (scale_value_i),
    .packed_byte_i (packed_byte_i),
    .cmd_i         (dp_cmd),
    .status_o      (dp_status),
    .out_ready_i   (out_ready_i),
    .out_valid_o   (out_valid_o),
    .elem_index_o  (elem_index_o),
    .value_o       (value_o),
    .last_o        (last_o)
  );

endmodule

FILE: hdl/nfdq_checker.sv
// Port-level checker for the NF4 double-quant dequantizer and its bind to the top level.
module nfdq_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_ready_o,
  input logic [nfdq_pkg::CMD_W-1:0]        command_i,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic [nfdq_pkg::IDX_W-1:0]        elem_index_o,
  input logic signed [nfdq_pkg::VAL_W-1:0] value_o,
  input logic                              last_o
);
  import nfdq_pkg::*;

  logic in_xfer, out_xfer;
  assign in_xfer  = in_valid_i && in_ready_o;
  assign out_xfer = out_valid_o && out_ready_i;

  // A result waiting at the output holds its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(elem_index_o)
                                       && $stable(value_o) && $stable(last_o)))
    else $error("output result changed while stalled");

  // The second result of a byte is loaded into the output register as the first leaves.
  a_second_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_xfer && !last_o) |=> out_valid_o)
    else $error("second result of a byte not presented after the first");

  // Scale commands leave the block ready in the next cycle.
  a_scale_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && ((command_i == CMD_SUPER) || (command_i == CMD_BLOCK))) |=> in_ready_o)
    else $error("not ready after a scale command");

  // A weight byte keeps the block busy while it is worked on.
  a_weight_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && (command_i == CMD_WEIGHT)) |=> !in_ready_o)
    else $error("ready straight after a weight byte");

endmodule

bind nf4_double_quant_dequantizer_core nfdq_checker u_nfdq_checker (.*);
